@@ rtl/rational_arithmetic_unit_macros.svh @@
// Assertion helpers.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RAU_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

@@ rtl/rau_pkg.sv @@
package rau_pkg;
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned InTdataW = 136;
  localparam int unsigned OutTdataW = 128;
  localparam int unsigned OutTuserW = 2;

  localparam logic [3:0] OpAdd = 4'd0;
  localparam logic [3:0] OpSub = 4'd1;
  localparam logic [3:0] OpMul = 4'd2;
  localparam logic [3:0] OpDiv = 4'd3;
  localparam logic [3:0] OpMod = 4'd4;
  localparam logic [3:0] OpLt  = 4'd5;
  localparam logic [3:0] OpLe  = 4'd6;
  localparam logic [3:0] OpGt  = 4'd7;
  localparam logic [3:0] OpGe  = 4'd8;
  localparam logic [3:0] OpEq  = 4'd9;
  localparam logic [3:0] OpNe  = 4'd10;
  localparam logic [3:0] OpInv = 4'd11;
  localparam logic [3:0] OpAbs = 4'd12;

  typedef struct packed {
    logic [3:0]         op;
    logic               err;
    logic signed [63:0] an;
    logic signed [63:0] ad;
    logic signed [63:0] bn;
    logic signed [63:0] bd;
  } rau_job_t;
endpackage

@@ rtl/rau_front.sv @@
module rau_front import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [InTdataW-1:0]  data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rau_job_t             job_o
);
  localparam int unsigned Depth = 2;
  rau_job_t q_q [Depth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  rau_job_t job;
  logic [3:0] op;
  logic [OPERAND_WIDTH-1:0] an_w, bn_w;
  logic [OPERAND_WIDTH-2:0] ad_w, bd_w;

  assign op   = data_i[3:0];
  assign an_w = data_i[4 +: OPERAND_WIDTH];
  assign ad_w = data_i[36 +: OPERAND_WIDTH-1];
  assign bn_w = data_i[67 +: OPERAND_WIDTH];
  assign bd_w = data_i[99 +: OPERAND_WIDTH-1];

  always_comb begin
    job.op = op;
    job.an = 64'(signed'(an_w));
    job.bn = 64'(signed'(bn_w));
    job.ad = signed'(64'(ad_w));
    job.bd = signed'(64'(bd_w));
    job.err = (op > OpAbs) || (ad_w == '0) || ((op <= OpNe) && (bd_w == '0)) ||
              (((op == OpDiv) || (op == OpMod)) && (bn_w == '0)) ||
              ((op == OpInv) && (an_w == '0));
  end

  assign ready_o = (cnt_q != 2'(Depth));
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) q_q[wp_q] <= job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (valid_i && ready_o) wp_q <= wp_q + 1'b1;
      if (valid_o && ready_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(valid_i && ready_o) - 2'(valid_o && ready_i);
    end
  end
endmodule

@@ rtl/rau_back.sv @@
module rau_back import rau_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  rau_job_t              job_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [OutTdataW-1:0]  data_o,
  output logic [OutTuserW-1:0]  user_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul  = 3'd1;
  localparam logic [2:0] SForm = 3'd2;
  localparam logic [2:0] SGcd  = 3'd3;
  localparam logic [2:0] SDiv  = 3'd4;
  localparam logic [2:0] SOut  = 3'd5;
  localparam logic [2:0] SMod  = 3'd6;

  logic [2:0] st_q, st_d;
  rau_job_t j_q;
  logic signed [63:0] l_q, r_q, dd_q, nn_q;
  logic [1:0] mc_q;
  logic [62:0] x_q, y_q, un_q, ud_q, g_q;
  logic [5:0] sh_q;
  logic neg_q;
  // restoring divider, shared by the modulo pass and the gcd division
  logic [62:0] quo_q, rem_q, dvd_q;
  logic [5:0] bit_q;
  logic dsel_q;
  logic signed [63:0] rn_q;
  logic [62:0] rd_q;
  logic truth_q, err_q;
  logic signed [63:0] modr_q;
  logic signed [63:0] mprod;
  logic signed [31:0] ma, mb;
  logic [63:0] rtry;
  logic rsub;
  logic [62:0] rem_n;

  assign ready_o = (st_q == SIdle);
  assign valid_o = (st_q == SOut);
  assign data_o  = {1'b0, rd_q, rn_q};
  assign user_o  = {err_q, truth_q};

  always_comb begin
    case (mc_q)
      2'd0:    begin ma = j_q.an[31:0]; mb = j_q.bd[31:0]; end
      2'd1:    begin ma = j_q.bn[31:0]; mb = j_q.ad[31:0]; end
      2'd2:    begin ma = j_q.ad[31:0]; mb = j_q.bd[31:0]; end
      default: begin ma = j_q.an[31:0]; mb = j_q.bn[31:0]; end
    endcase
    mprod = 64'(ma) * 64'(mb);
    rtry  = {rem_q, dvd_q[62]};
    rsub  = (rtry >= {1'b0, g_q});
    rem_n = rsub ? 63'(rtry - {1'b0, g_q}) : rtry[62:0];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (valid_i) st_d = SMul;
      SMul:  if (mc_q == 2'd3) st_d = (j_q.op == OpMod && !j_q.err) ? SMod : SForm;
      SMod:  if (bit_q == 6'd0) st_d = SForm;
      SForm: st_d = SGcd;
      SGcd:  if (y_q == '0) st_d = SDiv;
      SDiv:  if (bit_q == 6'd0 && dsel_q) st_d = SOut;
      SOut:  if (ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      mc_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == SMul) mc_q <= mc_q + 2'd1;
      else mc_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      SIdle: if (valid_i) j_q <= job_i;
      SMul: begin
        case (mc_q)
          2'd0:    l_q <= mprod;
          2'd1:    r_q <= mprod;
          2'd2:    dd_q <= mprod;
          default: begin
            nn_q  <= mprod;
            dvd_q <= 63'((l_q < 0) ? -l_q : l_q);
            g_q   <= 63'((r_q < 0) ? -r_q : r_q);
            rem_q <= '0;
            bit_q <= 6'd62;
          end
        endcase
      end
      SMod: begin
        // truncated remainder takes the sign of the dividend
        rem_q <= rem_n;
        dvd_q <= dvd_q << 1;
        if (bit_q == 6'd0) begin
          modr_q <= l_q[63] ? -signed'({1'b0, rem_n}) : signed'({1'b0, rem_n});
        end else begin
          bit_q <= bit_q - 6'd1;
        end
      end
      SForm: begin
        logic signed [63:0] n, d;
        logic t;
        n = 64'sd0; d = 64'sd1;
        t = 1'b0;
        err_q <= j_q.err;
        case (j_q.op)
          OpAdd: begin n = l_q + r_q; d = dd_q; end
          OpSub: begin n = l_q - r_q; d = dd_q; end
          OpMul: begin n = nn_q; d = dd_q; end
          OpDiv: begin n = l_q; d = r_q; end
          OpMod: begin n = modr_q; d = dd_q; end
          OpLt:  t = !j_q.err && (l_q < r_q);
          OpLe:  t = !j_q.err && (l_q <= r_q);
          OpGt:  t = !j_q.err && (l_q > r_q);
          OpGe:  t = !j_q.err && (l_q >= r_q);
          OpEq:  t = !j_q.err && (l_q == r_q);
          OpNe:  t = !j_q.err && (l_q != r_q);
          OpInv: begin n = j_q.ad; d = j_q.an; end
          OpAbs: begin n = (j_q.an < 0) ? -j_q.an : j_q.an; d = j_q.ad; end
          default: ;
        endcase
        if (j_q.err || (j_q.op >= OpLt && j_q.op <= OpNe)) begin
          n = 64'sd0; d = 64'sd1;
        end
        truth_q <= t;
        neg_q <= (n < 0) != (d < 0);
        un_q <= 63'((n < 0) ? -n : n);
        ud_q <= 63'((d < 0) ? -d : d);
        x_q  <= 63'((n < 0) ? -n : n);
        y_q  <= 63'((d < 0) ? -d : d);
        sh_q <= '0;
      end
      SGcd: begin
        // binary gcd: one step a cycle
        if (y_q == '0) begin
          g_q <= (x_q == '0) ? 63'd1 : (x_q << sh_q);
          dvd_q <= un_q; rem_q <= '0; bit_q <= 6'd62; dsel_q <= 1'b0;
        end else if (x_q == '0) begin
          x_q <= y_q; y_q <= '0;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1; y_q <= y_q >> 1; sh_q <= sh_q + 6'd1;
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= (x_q - y_q) >> 1;
        end else begin
          y_q <= (y_q - x_q) >> 1;
        end
      end
      SDiv: begin
        logic [62:0] qn;
        qn = {quo_q[61:0], rsub};
        if (bit_q == 6'd0 && !dsel_q) begin
          un_q <= qn;
          dvd_q <= ud_q; rem_q <= '0; bit_q <= 6'd62; dsel_q <= 1'b1;
        end else begin
          quo_q <= qn;
          rem_q <= rem_n;
          dvd_q <= dvd_q << 1;
          if (bit_q == 6'd0) begin
            rn_q <= (un_q == '0) ? 64'sd0 :
                    (neg_q ? -signed'({1'b0, un_q}) : signed'({1'b0, un_q}));
            rd_q <= (un_q == '0) ? 63'd1 : qn;
          end else begin
            bit_q <= bit_q - 6'd1;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit.
// Input stream s_axis: tdata holds op[3:0], num_a[35:4], den_a[66:36],
//   num_b[98:67], den_b[129:99], packed from bit 0 (130 bits used of 136).
// Output stream m_axis: tdata holds res_num[63:0], res_den[126:64];
//   tuser holds truth (bit 0) and error (bit 1).
// The front end classifies each beat, flags errors, sign-extends the
// numerators and zero-extends the denominators into a two-entry queue; the
// back end computes four products one per cycle on a shared multiplier, takes
// the modulo remainder with a restoring divider (modulo only), reduces with a
// binary gcd (one step per cycle) and divides both parts by the gcd with the
// same divider. One item is in the back end at a time.
// Reset clears the queue and the sequencer; no item survives it.
// A stalled receiver holds the result in the output register; the queue
// keeps accepting until full.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [InTdataW-1:0] s_axis_tdata,  // op, num_a, den_a, num_b, den_b
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // res_num, res_den
  output logic [OutTuserW-1:0] m_axis_tuser   // truth, error
);
  rau_job_t job;
  logic jv, jr;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .data_i(s_axis_tdata),
    .valid_o(jv), .ready_i(jr), .job_o(job)
  );

  rau_back u_back (
    .clk_i, .rst_ni,
    .valid_i(jv), .ready_o(jr), .job_i(job),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .data_o(m_axis_tdata), .user_o(m_axis_tuser)
  );
endmodule

@@ rtl/rau_checker.sv @@
`include "rational_arithmetic_unit_macros.svh"
module rau_checker import rau_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic [OutTuserW-1:0] m_axis_tuser
);
  `RAU_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `RAU_ASSERT(a_den, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[126:64] != 63'd0)
  `RAU_ASSERT(a_err, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata[63:0] == 64'd0)
  `RAU_ASSERT(a_gap, clk_i, rst_ni, m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
